@@ design/decimal_text_to_fixed_point_top_macros.svh @@
// Assertion macros shared by the checker of the decimal text parser.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_MACROS_SVH

// Checked only while out of reset.
`define DTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/dtf_pkg.sv @@
// Package for the decimal text to fixed point parser.
// Parse mode codes, status codes, character codes and powers of ten; no dependencies.
`timescale 1ns / 1ps

package dtf_pkg;

  localparam int CharW     = 8;
  localparam int ValueW    = 64;
  localparam int StatusW   = 2;
  localparam int OutUserW  = StatusW + 1;

  // parse modes
  localparam int ModeW = 3;
  localparam logic [ModeW-1:0] ModeStart    = 3'd0;
  localparam logic [ModeW-1:0] ModeInt      = 3'd1;
  localparam logic [ModeW-1:0] ModeFrac     = 3'd2;
  localparam logic [ModeW-1:0] ModeDoneOk   = 3'd3;
  localparam logic [ModeW-1:0] ModeDoneFail = 3'd4;

  // result status
  localparam logic [StatusW-1:0] StatusOpen = 2'd0;
  localparam logic [StatusW-1:0] StatusOk   = 2'd1;
  localparam logic [StatusW-1:0] StatusFail = 2'd2;

  // ASCII codes
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  // fraction weight table: up to nine digits, padded to a power of two
  localparam int WeightIdxW  = 4;
  localparam int WeightDepth = 16;

  localparam logic [63:0] Pow10 [10] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
    64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
  };

endpackage

@@ design/decimal_text_to_fixed_point_top.sv @@
// Decimal text to fixed point parser: one ASCII character per transaction in,
// one signed fixed-point result per string out. Uses dtf_pkg.
`timescale 1ns / 1ps

// Usage
//   Slave channel: s_axis_tdata carries one character, s_axis_tlast marks the
//   last character of a string. Master channel: m_axis_tdata is the signed
//   value with FRAC_BITS fraction bits, m_axis_tuser carries status and the
//   saturation flag. One result leaves for each string, none for others.
// Throughput
//   One character per cycle while s_axis_tready is high. The only loop is
//   the parse state update (integer times ten plus digit, or one fraction
//   weight add), which is combinational between the parse state registers.
// Pipeline
//   After the last character's transaction the result passes a snapshot of
//   the final parse state, then the result register (merge, clamp, sign),
//   which drives m_axis_tvalid.
// Reset
//   rst_ni low clears the parse state to the start mode and empties both
//   registers. No clearing pass is needed.
// Stall
//   While m_axis_tready is low the result holds; the snapshot stage still
//   takes one more string end, and only then is s_axis_tready dropped.
module decimal_text_to_fixed_point_top #(
  parameter int INT_BITS        = 31,
  parameter int FRAC_BITS       = 32,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dtf_pkg::CharW-1:0]      s_axis_tdata,   // [7:0] char_code
  input  logic                           s_axis_tlast,   // last
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dtf_pkg::ValueW-1:0]     m_axis_tdata,   // [63:0] value
  output logic [dtf_pkg::OutUserW-1:0]   m_axis_tuser    // [1:0] status, [2] saturated
);

  localparam int CntW     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int AccW     = INT_BITS + 4;
  localparam int FracAccW = FRAC_BITS + 1;
  localparam int MagW     = INT_BITS + FRAC_BITS + 1;
  localparam int ProdW    = FRAC_BITS + 4;

  localparam logic [63:0]          OneQ     = 64'd1 << FRAC_BITS;
  localparam logic [INT_BITS-1:0]  IntLim   = '1;
  localparam logic [MagW-2:0]      MagLim   = '1;

  // weight of fraction digit k+1: round(2^FRAC_BITS / 10^(k+1)), ties up
  localparam logic [FRAC_BITS-1:0] FracW [dtf_pkg::WeightDepth] = '{
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[1] / 2) / dtf_pkg::Pow10[1]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[2] / 2) / dtf_pkg::Pow10[2]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[3] / 2) / dtf_pkg::Pow10[3]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[4] / 2) / dtf_pkg::Pow10[4]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[5] / 2) / dtf_pkg::Pow10[5]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[6] / 2) / dtf_pkg::Pow10[6]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[7] / 2) / dtf_pkg::Pow10[7]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[8] / 2) / dtf_pkg::Pow10[8]),
    FRAC_BITS'((OneQ + dtf_pkg::Pow10[9] / 2) / dtf_pkg::Pow10[9]),
    '0, '0, '0, '0, '0, '0, '0
  };

  // parse state
  logic [dtf_pkg::ModeW-1:0] mode_q, mode_d;
  logic                      neg_q, neg_d;
  logic [INT_BITS-1:0]       int_q, int_d;
  logic [FracAccW-1:0]       frac_q, frac_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;

  // snapshot stage
  logic                        s1_valid_q;
  logic                        s1_neg_q;
  logic [INT_BITS-1:0]         s1_int_q;
  logic [FracAccW-1:0]         s1_frac_q;
  logic                        s1_ovf_q;
  logic [dtf_pkg::StatusW-1:0] s1_status_q;
  logic [dtf_pkg::StatusW-1:0] status_d;
  logic                        s1_ready;

  // result stage
  logic                        out_valid_q;
  logic [dtf_pkg::ValueW-1:0]  out_value_q, out_value_d;
  logic [dtf_pkg::StatusW-1:0] out_status_q;
  logic                        out_sat_q, out_sat_d;

  logic                        in_acc;
  logic                        is_digit, is_space;
  logic [3:0]                  digit;
  logic [AccW-1:0]             int_prod;
  logic                        int_over;
  logic [INT_BITS-1:0]         int_next;
  logic [dtf_pkg::WeightIdxW-1:0] widx;
  logic [ProdW-1:0]            frac_prod;
  logic [FracAccW-1:0]         frac_next;
  logic                        cnt_ok;

  logic [INT_BITS:0]           mag_hi;
  logic [MagW-1:0]             mag_raw;
  logic [MagW-2:0]             mag;
  logic [dtf_pkg::ValueW-1:0]  mag_ext;

  assign s1_ready      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // character classes
  assign is_digit = (s_axis_tdata >= dtf_pkg::CharZero) && (s_axis_tdata <= dtf_pkg::CharNine);
  assign is_space = (s_axis_tdata == dtf_pkg::CharSpace) ||
                    ((s_axis_tdata >= dtf_pkg::CharTab) && (s_axis_tdata <= dtf_pkg::CharCr));
  assign digit    = 4'(s_axis_tdata - dtf_pkg::CharZero);

  // integer: acc * 10 + d as two shifts and adds, clamped
  assign int_prod = (AccW'(int_q) << 3) + (AccW'(int_q) << 1) + AccW'(digit);
  assign int_over = int_prod > AccW'(IntLim);
  assign int_next = int_over ? IntLim : int_prod[INT_BITS-1:0];

  // fraction: add digit times the weight of the next position
  assign widx      = dtf_pkg::WeightIdxW'(cnt_q);
  assign frac_prod = ProdW'(FracW[widx]) * ProdW'(digit);
  assign frac_next = frac_q + frac_prod[FracAccW-1:0];
  assign cnt_ok    = cnt_q < CntW'(MAX_FRAC_DIGITS);

  always_comb begin
    mode_d = mode_q;
    neg_d  = neg_q;
    int_d  = int_q;
    frac_d = frac_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    unique case (mode_q)
      dtf_pkg::ModeStart: begin
        if (s_axis_tdata == dtf_pkg::CharPlus) begin
          mode_d = dtf_pkg::ModeInt;
        end else if (s_axis_tdata == dtf_pkg::CharMinus) begin
          mode_d = dtf_pkg::ModeInt;
          neg_d  = 1'b1;
        end else if (s_axis_tdata == dtf_pkg::CharDot) begin
          mode_d = dtf_pkg::ModeFrac;
        end else if (is_digit) begin
          // accumulator is still zero here
          mode_d = dtf_pkg::ModeInt;
          int_d  = int_next;
          ovf_d  = ovf_q | int_over;
        end else if (!is_space) begin
          mode_d = dtf_pkg::ModeDoneFail;
        end
      end
      dtf_pkg::ModeInt: begin
        if (is_digit) begin
          int_d = int_next;
          ovf_d = ovf_q | int_over;
        end else if (s_axis_tdata == dtf_pkg::CharDot) begin
          mode_d = dtf_pkg::ModeFrac;
        end else begin
          mode_d = dtf_pkg::ModeDoneFail;
        end
      end
      dtf_pkg::ModeFrac: begin
        if (is_digit) begin
          // digits past the limit are dropped
          if (cnt_ok) begin
            cnt_d  = cnt_q + CntW'(1);
            frac_d = frac_next;
          end
        end else begin
          mode_d = dtf_pkg::ModeDoneOk;
        end
      end
      default: begin
        // finished: ignore until end of string
      end
    endcase
  end

  always_comb begin
    if (mode_d == dtf_pkg::ModeDoneOk) begin
      status_d = dtf_pkg::StatusOk;
    end else if (mode_d == dtf_pkg::ModeDoneFail) begin
      status_d = dtf_pkg::StatusFail;
    end else begin
      status_d = dtf_pkg::StatusOpen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dtf_pkg::ModeStart;
      neg_q  <= 1'b0;
      int_q  <= '0;
      frac_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        mode_q <= dtf_pkg::ModeStart;
        neg_q  <= 1'b0;
        int_q  <= '0;
        frac_q <= '0;
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        mode_q <= mode_d;
        neg_q  <= neg_d;
        int_q  <= int_d;
        frac_q <= frac_d;
        cnt_q  <= cnt_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // snapshot of the final state of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      s1_valid_q <= 1'b1;
    end else if (s1_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      s1_neg_q    <= neg_d;
      s1_int_q    <= int_d;
      s1_frac_q   <= frac_d;
      s1_ovf_q    <= ovf_d;
      s1_status_q <= status_d;
    end
  end

  // fraction is below 2^(FRAC_BITS+1): its top bit only increments the integer
  assign mag_hi      = {1'b0, s1_int_q} + (INT_BITS + 1)'(s1_frac_q[FRAC_BITS]);
  assign mag_raw     = {mag_hi, s1_frac_q[FRAC_BITS-1:0]};
  assign mag         = mag_raw[MagW-1] ? MagLim : mag_raw[MagW-2:0];
  assign mag_ext     = dtf_pkg::ValueW'(mag);
  assign out_value_d = s1_neg_q ? (~mag_ext + dtf_pkg::ValueW'(1)) : mag_ext;
  assign out_sat_d   = s1_ovf_q | mag_raw[MagW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ready) begin
      out_value_q  <= out_value_d;
      out_status_q <= s1_status_q;
      out_sat_q    <= out_sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = {out_sat_q, out_status_q};

endmodule

@@ design/dtf_checker.sv @@
// Port-level checker for the decimal text parser, bound to its top level.
// Uses dtf_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_point_top_macros.svh"

module dtf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dtf_pkg::ValueW-1:0]   m_axis_tdata,
  input logic [dtf_pkg::OutUserW-1:0] m_axis_tuser
);

  logic [dtf_pkg::StatusW-1:0] status;

  assign status    = m_axis_tuser[dtf_pkg::StatusW-1:0];

  // after reset is seen low at an edge the result register is empty
  `DTF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

  // input only stalls when both stages hold a result the receiver refuses
  `DTF_ASSERT(a_stall_cause, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
    "input stalled without output backpressure")

  // status is one of the three defined codes
  `DTF_ASSERT(a_status_code, m_axis_tvalid |-> (status == dtf_pkg::StatusOpen ||
    status == dtf_pkg::StatusOk || status == dtf_pkg::StatusFail), "bad status code")

  // a refused result holds its payload
  `DTF_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid &&
    $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind decimal_text_to_fixed_point_top dtf_checker u_dtf_checker (.*);
